// ===== src/assert_macros.svh =====
// Assertion macros used by the controller module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks that a property holds on every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that a condition implies a property on the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);
`endif

// ===== src/sgdb_pkg.sv =====
// Shared types and constants of the scatter-gather descriptor builder.
package sgdb_pkg;
  localparam int unsigned MaxSegsDefault   = 16;
  localparam int unsigned DescBytesDefault = 64;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 5;

  localparam logic [1:0] FuncLoadData = 2'd0;
  localparam logic [1:0] FuncLoadDesc = 2'd1;
  localparam logic [1:0] FuncAddBuf   = 2'd2;
  localparam logic [1:0] FuncRestart  = 2'd3;

  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatDataFull = 2'd1;
  localparam logic [1:0] StatDescFull = 2'd2;
  localparam logic [1:0] StatZeroSize = 2'd3;

  localparam logic [CfgIdxW-1:0] CfgDataCount = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgDescCount = 1'd1;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  seg_index;
    logic [63:0] seg_addr;
    logic [31:0] seg_len;
    logic [31:0] buffer_size;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] desc_offset;
    logic [63:0] desc_addr;
    logic [63:0] buffer_addr;
    logic [31:0] piece_len;
    logic        start_flag;
    logic        end_flag;
    logic        last;
  } res_t;

  // Datapath commands issued by the controller.
  typedef enum logic [3:0] {
    CmdNone, CmdLoad, CmdRestart, CmdInit, CmdDataStep, CmdDescStep,
    CmdDescScan, CmdRecord, CmdAdvance, CmdCommit, CmdEmit, CmdFail
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [1:0] code;
    logic       run;
  } ctl_t;

  typedef struct packed {
    logic data_found;
    logic data_end;
    logic desc_found;
    logic desc_fit;
    logic desc_end;
    logic slot_ovf;
    logic remain_zero;
    logic cur_ovf_data;
    logic cur_ovf_desc;
    logic emit_last;
    logic size_zero;
  } stat_t;
endpackage

// ===== src/sgdb_if.sv =====
// Valid/ready channel interface carrying one payload.
interface sgdb_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/sg_descriptor_builder.sv =====
// Top level of the scatter-gather descriptor builder.
// The block takes request transactions on in_ch: loads of the data and
// descriptor segment tables, a cursor restart, or an add-buffer request.
// Loads and restart give no result. An add-buffer
// request walks the data table to the data cursor, then for each piece
// locates a descriptor slot by walking the descriptor table, one entry per
// cycle. A request with a zero size goes straight to the failure state and
// reports its status from there. Results leave on out_ch, one transaction
// per piece with last on the final one, or a single status transaction on
// failure, in which case the cursors keep their values.
// The output register holds a result while the receiver stalls; the
// sequencer waits for it before producing the next one, while new requests
// may still be taken once the sequencer is idle. Reset clears the cursors,
// the counts and the control state; table contents stay undefined until
// loaded. The user must make configuration writes only while the block is
// idle; the block itself does not enforce it.
module sg_descriptor_builder #(
  parameter int unsigned MaxSegs   = sgdb_pkg::MaxSegsDefault,
  parameter int unsigned DescBytes = sgdb_pkg::DescBytesDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [sgdb_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sgdb_pkg::CfgDataW-1:0] cfg_data_i,
  sgdb_if.sink   in_ch,
  sgdb_if.source out_ch
);
  import sgdb_pkg::*;
  logic [4:0] data_cnt_q, desc_cnt_q;
  ctl_t ctl;
  stat_t stat;
  res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_cnt_q <= '0; desc_cnt_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgDataCount) data_cnt_q <= cfg_data_i;
      else if (cfg_idx_i == CfgDescCount) desc_cnt_q <= cfg_data_i;
    end
  end

  sgdb_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready), .func_i(in_ch.data.func),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready),
    .stat_i(stat), .ctl_o(ctl)
  );

  sgdb_datapath #(.MaxSegs(MaxSegs), .DescBytes(DescBytes)) u_dp (
    .clk_i, .rst_ni, .req_i(in_ch.data), .data_cnt_i(data_cnt_q),
    .desc_cnt_i(desc_cnt_q), .ctl_i(ctl), .stat_o(stat), .res_o(res)
  );
  assign out_ch.data = res;
endmodule

// ===== src/sgdb_datapath.sv =====
// Segment tables, cursors, piece buffer and output register.
module sgdb_datapath #(
  parameter int unsigned MaxSegs   = sgdb_pkg::MaxSegsDefault,
  parameter int unsigned DescBytes = sgdb_pkg::DescBytesDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sgdb_pkg::req_t req_i,
  input  logic [4:0]     data_cnt_i,
  input  logic [4:0]     desc_cnt_i,
  input  sgdb_pkg::ctl_t ctl_i,
  output sgdb_pkg::stat_t stat_o,
  output sgdb_pkg::res_t res_o
);
  import sgdb_pkg::*;
  localparam int unsigned IdxW = (MaxSegs > 1) ? $clog2(MaxSegs) : 1;
  localparam int unsigned CntW = $clog2(MaxSegs + 1);

  logic [63:0] dseg_addr [MaxSegs];
  logic [31:0] dseg_len  [MaxSegs];
  logic [63:0] sseg_addr [MaxSegs];
  logic [31:0] sseg_len  [MaxSegs];
  logic [31:0] p_slot  [MaxSegs];
  logic [63:0] p_daddr [MaxSegs];
  logic [63:0] p_baddr [MaxSegs];
  logic [31:0] p_len   [MaxSegs];

  logic [31:0] data_cur_q, desc_cur_q;
  logic [CntW-1:0] di_q, si_q, k_q, m_q, dn, sn;
  logic [32:0] doff_q, soff_q, dcur_q, scur_q, slot_q;
  logic [32:0] din_q, sin_q, remain_q;
  logic [63:0] saddr_q;
  logic [31:0] size_q;
  res_t res_q;

  always_comb begin
    dn = (32'(data_cnt_i) > MaxSegs) ? CntW'(MaxSegs) : CntW'(data_cnt_i);
    sn = (32'(desc_cnt_i) > MaxSegs) ? CntW'(MaxSegs) : CntW'(desc_cnt_i);
  end

  logic [IdxW-1:0] di_ix, si_ix, k_ix, m_ix, ld_ix;
  logic [32:0] dlen, slen, dspace, sspace, plen, new_slot_end;
  assign di_ix = di_q[IdxW-1:0];
  assign si_ix = si_q[IdxW-1:0];
  assign k_ix  = k_q[IdxW-1:0];
  assign m_ix  = m_q[IdxW-1:0];
  assign ld_ix = IdxW'(req_i.seg_index);
  assign dlen  = (di_q < dn) ? {1'b0, dseg_len[di_ix]} : '0;
  assign slen  = (si_q < sn) ? {1'b0, sseg_len[si_ix]} : '0;
  assign dspace = dlen - din_q;
  assign sspace = slen - sin_q;
  assign plen = (dspace < remain_q) ? dspace : remain_q;
  assign new_slot_end = slot_q + 33'(DescBytes);

  always_comb begin
    stat_o = '0;
    stat_o.data_end    = (di_q >= dn);
    stat_o.data_found  = (di_q < dn) && (din_q < dlen);
    stat_o.desc_end    = (si_q >= sn);
    stat_o.desc_found  = (si_q < sn) && (sin_q < slen);
    stat_o.desc_fit    = (si_q < sn) && (33'(DescBytes) <= sspace);
    stat_o.slot_ovf    = slot_q[32];
    stat_o.remain_zero = (remain_q == '0);
    stat_o.cur_ovf_data = dcur_q[32];
    stat_o.cur_ovf_desc = scur_q[32];
    stat_o.emit_last   = (m_q + 1'b1 == k_q);
    stat_o.size_zero   = (req_i.buffer_size == '0);
  end

  // Tables and piece buffer: no reset.
  always_ff @(posedge clk_i) begin
    if (ctl_i.cmd == CmdLoad && 32'(req_i.seg_index) < MaxSegs) begin
      if (req_i.func == FuncLoadData) begin
        dseg_addr[ld_ix] <= req_i.seg_addr;
        dseg_len[ld_ix]  <= req_i.seg_len;
      end else begin
        sseg_addr[ld_ix] <= req_i.seg_addr;
        sseg_len[ld_ix]  <= req_i.seg_len;
      end
    end
    if (ctl_i.cmd == CmdRecord) begin
      p_slot[k_ix]  <= slot_q[31:0];
      p_daddr[k_ix] <= saddr_q;
      p_baddr[k_ix] <= dseg_addr[di_ix] + 64'(din_q[31:0]);
      p_len[k_ix]   <= plen[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_cur_q <= '0;
      desc_cur_q <= '0;
    end else if (ctl_i.cmd == CmdRestart) begin
      data_cur_q <= '0;
      desc_cur_q <= '0;
    end else if (ctl_i.cmd == CmdCommit) begin
      data_cur_q <= dcur_q[31:0];
      desc_cur_q <= scur_q[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.cmd)
      CmdInit: begin
        size_q <= req_i.buffer_size;
        remain_q <= {1'b0, req_i.buffer_size};
        di_q <= '0; din_q <= {1'b0, data_cur_q};
        dcur_q <= {1'b0, data_cur_q};
        scur_q <= {1'b0, desc_cur_q};
        si_q <= '0; sin_q <= {1'b0, desc_cur_q};
        k_q <= '0;
      end
      // Walk the data table towards the segment holding the cursor.
      CmdDataStep: begin
        din_q <= din_q - dlen;
        di_q <= di_q + 1'b1;
      end
      // Locate the descriptor cursor within the table.
      CmdDescStep: begin
        if (stat_o.desc_found) begin
          slot_q <= scur_q;
          saddr_q <= sseg_addr[si_ix] + 64'(sin_q[31:0]);
        end else begin
          sin_q <= sin_q - slen;
          si_q <= si_q + 1'b1;
        end
      end
      // Skip whole segments when the slot does not fit.
      CmdDescScan: begin
        slot_q <= slot_q + sspace;
        sin_q <= '0;
        si_q <= si_q + 1'b1;
        saddr_q <= sseg_addr[(si_q + 1'b1 < CntW'(MaxSegs)) ?
                             IdxW'(si_q + 1'b1) : si_ix];
      end
      // The next candidate slot follows directly after the one just taken.
      CmdRecord: begin
        k_q <= k_q + 1'b1;
        remain_q <= remain_q - plen;
        dcur_q <= dcur_q + plen;
        scur_q <= new_slot_end;
        slot_q <= new_slot_end;
        saddr_q <= saddr_q + 64'(DescBytes);
        sin_q <= sin_q + 33'(DescBytes);
      end
      CmdAdvance: begin
        di_q <= di_q + 1'b1;
        din_q <= '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.cmd)
      CmdInit: m_q <= '0;
      CmdEmit: m_q <= m_q + 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cmd == CmdFail) begin
      res_q <= '{status: ctl_i.code, last: 1'b1, default: '0};
    end else if (ctl_i.cmd == CmdEmit) begin
      res_q.status <= StatOk;
      res_q.desc_offset <= p_slot[m_ix];
      res_q.desc_addr <= p_daddr[m_ix];
      res_q.buffer_addr <= p_baddr[m_ix];
      res_q.piece_len <= p_len[m_ix];
      res_q.start_flag <= (m_q == '0);
      res_q.end_flag <= stat_o.emit_last;
      res_q.last <= stat_o.emit_last;
    end
  end
  assign res_o = res_q;

  logic unused;
  assign unused = ^size_q ^ ctl_i.run;
endmodule

// ===== src/sgdb_ctrl.sv =====
// Controller state machine sequencing requests through the datapath.
`include "assert_macros.svh"
module sgdb_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      func_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  sgdb_pkg::stat_t stat_i,
  output sgdb_pkg::ctl_t  ctl_o
);
  import sgdb_pkg::*;
  typedef enum logic [3:0] {
    SIdle, SDataLoc, SDescLoc, SDescScan, SRecord, SNextSeg, SFinal,
    SEmit, SOut, SFail
  } state_e;
  state_e state_q;
  logic [1:0] code_q;
  logic out_valid_q, last_q;

  // A result waiting in the output register does not hold back new requests.
  assign in_ready_o = (state_q == SIdle);
  assign out_valid_o = out_valid_q;

  logic acc;
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    ctl_o = '0;
    ctl_o.cmd = CmdNone;
    ctl_o.code = code_q;
    ctl_o.run = (state_q != SIdle);
    case (state_q)
      SIdle: begin
        if (acc) begin
          if (func_i == FuncLoadData || func_i == FuncLoadDesc) ctl_o.cmd = CmdLoad;
          else if (func_i == FuncRestart) ctl_o.cmd = CmdRestart;
          else if (!stat_i.size_zero) ctl_o.cmd = CmdInit;
        end
      end
      SDataLoc: if (!stat_i.data_found && !stat_i.data_end) ctl_o.cmd = CmdDataStep;
      SDescLoc: if (!stat_i.desc_end) ctl_o.cmd = CmdDescStep;
      SDescScan: if (!stat_i.desc_fit && !stat_i.desc_end) ctl_o.cmd = CmdDescScan;
      SRecord: ctl_o.cmd = CmdRecord;
      SNextSeg: ctl_o.cmd = CmdAdvance;
      SFinal: if (!stat_i.cur_ovf_desc && !stat_i.cur_ovf_data) ctl_o.cmd = CmdCommit;
      SEmit: if (!out_valid_q || out_ready_i) ctl_o.cmd = CmdEmit;
      SFail: if (!out_valid_q || out_ready_i) ctl_o.cmd = CmdFail;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; code_q <= StatOk; out_valid_q <= 1'b0; last_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        SIdle: begin
          if (acc && func_i == FuncAddBuf && stat_i.size_zero) begin
            code_q <= StatZeroSize; state_q <= SFail;
          end else if (ctl_o.cmd == CmdInit) state_q <= SDataLoc;
        end
        SDataLoc: begin
          if (stat_i.data_found) state_q <= SDescLoc;
          else if (stat_i.data_end) begin
            code_q <= StatDataFull; state_q <= SFail;
          end
        end
        SDescLoc: begin
          if (stat_i.desc_end) begin
            code_q <= StatDescFull; state_q <= SFail;
          end else if (stat_i.desc_found) state_q <= SDescScan;
        end
        SDescScan: begin
          if (stat_i.desc_fit) begin
            if (stat_i.slot_ovf) begin
              code_q <= StatDescFull; state_q <= SFail;
            end else state_q <= SRecord;
          end else if (stat_i.desc_end) begin
            code_q <= StatDescFull; state_q <= SFail;
          end
        end
        SRecord: state_q <= SNextSeg;
        SNextSeg: begin
          // Recording left remain and cursors updated; decide on the next piece.
          if (stat_i.remain_zero) state_q <= SFinal;
          else state_q <= SOut;
        end
        SOut: begin
          if (stat_i.data_end) begin
            code_q <= StatDataFull; state_q <= SFail;
          end else if (stat_i.data_found) state_q <= SDescScan;
          else state_q <= SNextSeg;
        end
        SFinal: begin
          if (stat_i.cur_ovf_desc) begin
            code_q <= StatDescFull; state_q <= SFail;
          end else if (stat_i.cur_ovf_data) begin
            code_q <= StatDataFull; state_q <= SFail;
          end else state_q <= SEmit;
        end
        SEmit: if (ctl_o.cmd == CmdEmit) begin
          out_valid_q <= 1'b1; last_q <= stat_i.emit_last;
          if (stat_i.emit_last) state_q <= SIdle;
        end
        SFail: if (ctl_o.cmd == CmdFail) begin
          out_valid_q <= 1'b1; last_q <= 1'b1; state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  `ASSERT_NEXT(a_emit_valid, clk_i, rst_ni, ctl_o.cmd == CmdEmit, out_valid_o,
    "emitted result not presented")
  `ASSERT_CLK(a_ready_idle, clk_i, rst_ni, !in_ready_o || state_q == SIdle,
    "request taken while busy")
  `ASSERT_NEXT(a_no_commit_fail, clk_i, rst_ni, ctl_o.cmd == CmdCommit,
    state_q == SEmit, "commit not followed by emission")
  logic unused;
  assign unused = last_q;
endmodule
